/* src/fpp_pkg.sv */
`default_nettype none

package fpp_pkg;

  localparam int PAGE_SHIFT = 21;
  localparam int POOL_DEPTH = 4096;
  localparam int ADDR_W     = 64;
  localparam int PN_W       = ADDR_W - PAGE_SHIFT;
  localparam int IDX_W      = $clog2(POOL_DEPTH);
  localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
  localparam int STATUS_W   = 3;
  localparam int REL_W      = 13;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 1;

  localparam logic [ADDR_W-1:0] PAGE_BYTES  = ADDR_W'(1) << PAGE_SHIFT;
  localparam logic [ADDR_W-1:0] PAGE_MASK   = PAGE_BYTES - ADDR_W'(1);
  localparam logic [ADDR_W-1:0] LIMIT_RESET = 64'hffff800040000000;

  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FREE   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REGION = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BELOW      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABOVE      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 1'b1;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [PN_W-1:0]  wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

/* src/free_page_pool.sv */
// Channel   Handshake                Payload
// in_       start / busy             in_req_type, in_page_addr, in_region_start, in_region_end
// out_      out_valid (one cycle)    out_status, out_alloc_addr, out_pages_released
// cfg_      cfg_we                   cfg_index, cfg_wdata
//
// One request is worked on at a time; busy is high while it is in flight, and the next request
// can be taken at the edge that ends the result cycle. Allocate and free make one stack access;
// allocate from an empty pool answers without one. Region release steps through S_REG_A to
// S_REG_D, then pushes its pages (the stack write port takes one page a cycle); an empty range
// ends the request in S_REG_B or S_REG_C. Results cannot be stalled.
// Synchronous active-low reset empties the pool; the stack memory itself is not cleared.
`default_nettype none

module free_page_pool
  import fpp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [ADDR_W-1:0]    in_page_addr,
  input  wire logic [ADDR_W-1:0]    in_region_start,
  input  wire logic [ADDR_W-1:0]    in_region_end,
  output logic                      out_valid,
  output logic      [STATUS_W-1:0]  out_status,
  output logic      [ADDR_W-1:0]    out_alloc_addr,
  output logic      [REL_W-1:0]     out_pages_released,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata
);

  logic [ADDR_W-1:0] lowest_r, lowest_nxt;
  logic [ADDR_W-1:0] upper_r,  upper_nxt;
  mem_req_t          mem_req;
  logic [PN_W-1:0]   mem_rdata;

  always_comb begin
    lowest_nxt = lowest_r;
    upper_nxt  = upper_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOWEST: lowest_nxt = cfg_wdata;
        CFG_UPPER:  upper_nxt  = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowest_r <= '0;
      upper_r  <= LIMIT_RESET;
    end else begin
      lowest_r <= lowest_nxt;
      upper_r  <= upper_nxt;
    end
  end

  fpp_stack_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  fpp_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_page_addr       (in_page_addr),
    .in_region_start    (in_region_start),
    .in_region_end      (in_region_end),
    .lowest_address     (lowest_r),
    .upper_limit        (upper_r),
    .mem_req            (mem_req),
    .mem_rdata          (mem_rdata),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_alloc_addr     (out_alloc_addr),
    .out_pages_released (out_pages_released)
  );

endmodule

`default_nettype wire

/* src/fpp_stack_mem.sv */
`default_nettype none

module fpp_stack_mem
  import fpp_pkg::*;
(
  input  wire logic            clk,
  input  mem_req_t             req,
  output logic     [PN_W-1:0]  rdata
);

  logic [PN_W-1:0] mem [POOL_DEPTH];
  logic [PN_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* src/fpp_ctrl.sv */
`default_nettype none

module fpp_ctrl
  import fpp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [REQ_W-1:0]     in_req_type,
  input  wire logic [ADDR_W-1:0]    in_page_addr,
  input  wire logic [ADDR_W-1:0]    in_region_start,
  input  wire logic [ADDR_W-1:0]    in_region_end,
  input  wire logic [ADDR_W-1:0]    lowest_address,
  input  wire logic [ADDR_W-1:0]    upper_limit,
  output mem_req_t                  mem_req,
  input  wire logic [PN_W-1:0]      mem_rdata,
  output logic                      out_valid,
  output logic      [STATUS_W-1:0]  out_status,
  output logic      [ADDR_W-1:0]    out_alloc_addr,
  output logic      [REL_W-1:0]     out_pages_released
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_REG_A = 3'd3;
  localparam logic [2:0] S_REG_B = 3'd4;
  localparam logic [2:0] S_REG_C = 3'd5;
  localparam logic [2:0] S_REG_D = 3'd6;
  localparam logic [2:0] S_PUSH  = 3'd7;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(POOL_DEPTH);

  logic [2:0]          state_r,  state_nxt;
  logic [CNT_W-1:0]    count_r,  count_nxt;
  logic [ADDR_W-1:0]   a_r,      a_nxt;      // page address, then range low bound
  logic [ADDR_W-1:0]   b_r,      b_nxt;      // range end, then clipped high bound
  logic [ADDR_W-1:0]   lo_k_r,   lo_k_nxt;
  logic                fail_r,   fail_nxt;
  logic [CNT_W-1:0]    n_r,      n_nxt;
  logic [CNT_W-1:0]    pushed_r, pushed_nxt;
  logic                full_r,   full_nxt;
  logic [PN_W-1:0]     pn_r,     pn_nxt;
  logic                vld_r,    vld_nxt;
  logic [STATUS_W-1:0] st_r,     st_nxt;
  logic [ADDR_W-1:0]   alloc_r,  alloc_nxt;
  logic [CNT_W-1:0]    rel_r,    rel_nxt;

  logic [CNT_W-1:0]    count_m1;
  logic [CNT_W-1:0]    room;
  logic [ADDR_W:0]     sum_s, sum_k, sum_p, diff;
  logic                misaligned, below, above;

  assign busy     = (state_r != S_IDLE);
  assign count_m1 = count_r - CNT_W'(1);
  assign room     = DEPTH_CNT - count_r;

  assign sum_s = {1'b0, a_r} + {1'b0, PAGE_MASK};
  assign sum_k = {1'b0, lowest_address} + {1'b0, PAGE_MASK};
  assign sum_p = {1'b0, a_r} + {1'b0, PAGE_BYTES};
  assign diff  = {1'b0, b_r} - {1'b0, a_r};

  assign misaligned = |(a_r & PAGE_MASK);
  assign below      = a_r < lowest_address;
  // The sum keeps its carry, so the limit test never wraps.
  assign above      = sum_p > {1'b0, upper_limit};

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    lo_k_nxt   = lo_k_r;
    fail_nxt   = fail_r;
    n_nxt      = n_r;
    pushed_nxt = pushed_r;
    full_nxt   = full_r;
    pn_nxt     = pn_r;
    vld_nxt    = 1'b0;
    st_nxt     = st_r;
    alloc_nxt  = alloc_r;
    rel_nxt    = rel_r;
    mem_req    = '0;
    mem_req.waddr = count_r[IDX_W-1:0];
    mem_req.raddr = count_m1[IDX_W-1:0];
    mem_req.wdata = pn_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          st_nxt    = ST_OK;
          alloc_nxt = '0;
          rel_nxt   = '0;
          unique case (in_req_type)
            REQ_ALLOC: begin
              if (count_r == '0) begin
                vld_nxt = 1'b1;
                st_nxt  = ST_EMPTY;
              end else begin
                mem_req.re = 1'b1;
                count_nxt  = count_m1;
                state_nxt  = S_ALLOC;
              end
            end
            REQ_FREE: begin
              a_nxt     = in_page_addr;
              state_nxt = S_FREE;
            end
            REQ_REGION: begin
              a_nxt     = in_region_start;
              b_nxt     = in_region_end;
              state_nxt = S_REG_A;
            end
            default: begin
              vld_nxt = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        vld_nxt   = 1'b1;
        alloc_nxt = {mem_rdata, PAGE_SHIFT'(0)};
        state_nxt = S_IDLE;
      end
      S_FREE: begin
        vld_nxt   = 1'b1;
        state_nxt = S_IDLE;
        if (misaligned) begin
          st_nxt = ST_MISALIGNED;
        end else if (below) begin
          st_nxt = ST_BELOW;
        end else if (above) begin
          st_nxt = ST_ABOVE;
        end else if (count_r == DEPTH_CNT) begin
          st_nxt = ST_FULL;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wdata = a_r[ADDR_W-1:PAGE_SHIFT];
          count_nxt     = count_r + CNT_W'(1);
        end
      end
      S_REG_A: begin
        // Round both low bounds up to a page; a carry out means the range is empty.
        a_nxt     = sum_s[ADDR_W-1:0] & ~PAGE_MASK;
        lo_k_nxt  = sum_k[ADDR_W-1:0] & ~PAGE_MASK;
        fail_nxt  = sum_s[ADDR_W] | sum_k[ADDR_W];
        b_nxt     = (b_r < upper_limit) ? b_r : upper_limit;
        state_nxt = S_REG_B;
      end
      S_REG_B: begin
        if (fail_r) begin
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (lo_k_r > a_r) begin
            a_nxt = lo_k_r;
          end
          state_nxt = S_REG_C;
        end
      end
      S_REG_C: begin
        if (diff[ADDR_W]) begin
          vld_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // Page count saturates; anything past the pool depth is treated alike.
          if (|diff[ADDR_W-1:PAGE_SHIFT+CNT_W]) begin
            n_nxt = '1;
          end else begin
            n_nxt = diff[PAGE_SHIFT+CNT_W-1:PAGE_SHIFT];
          end
          pn_nxt    = a_r[ADDR_W-1:PAGE_SHIFT];
          state_nxt = S_REG_D;
        end
      end
      S_REG_D: begin
        if (n_r > room) begin
          n_nxt    = room;
          full_nxt = 1'b1;
        end else begin
          full_nxt = 1'b0;
        end
        pushed_nxt = '0;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        if (pushed_r == n_r) begin
          vld_nxt   = 1'b1;
          st_nxt    = full_r ? ST_FULL : ST_OK;
          rel_nxt   = pushed_r;
          state_nxt = S_IDLE;
        end else begin
          mem_req.we = 1'b1;
          count_nxt  = count_r + CNT_W'(1);
          pn_nxt     = pn_r + PN_W'(1);
          pushed_nxt = pushed_r + CNT_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
    end
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    lo_k_r   <= lo_k_nxt;
    fail_r   <= fail_nxt;
    n_r      <= n_nxt;
    pushed_r <= pushed_nxt;
    full_r   <= full_nxt;
    pn_r     <= pn_nxt;
    st_r     <= st_nxt;
    alloc_r  <= alloc_nxt;
    rel_r    <= rel_nxt;
  end

  assign out_valid          = vld_r;
  assign out_status         = st_r;
  assign out_alloc_addr     = alloc_r;
  assign out_pages_released = REL_W'(rel_r);

endmodule

`default_nettype wire

/* sim/free_page_pool_tb.sv */
module free_page_pool_tb
  import fpp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 8;
  localparam int QUIET_LIMIT = 20000;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_addr;
    logic [REL_W-1:0]    released;
  } pool_result_t;

  class page_pool_scoreboard;
    logic [ADDR_W-1:0] lowest_addr;
    logic [ADDR_W-1:0] upper_lim;
    logic [PN_W-1:0]   page_stack [POOL_DEPTH];
    int unsigned       depth_used;
    pool_result_t      pending_results[$];
    int                errors;

    function new();
      lowest_addr = '0;
      upper_lim   = LIMIT_RESET;
      depth_used  = 0;
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      if (idx == CFG_LOWEST) lowest_addr = val;
      else upper_lim = val;
    endfunction

    function void stash(logic [ADDR_W-1:0] page);
      page_stack[depth_used] = page[ADDR_W-1:PAGE_SHIFT];
      depth_used++;
    endfunction

    function pool_result_t alloc_page();
      pool_result_t res;
      res = '0;
      if (depth_used == 0) begin
        res.status = ST_EMPTY;
      end else begin
        depth_used--;
        res.alloc_addr = ADDR_W'(page_stack[depth_used]) << PAGE_SHIFT;
      end
      return res;
    endfunction

    // Checks are ordered: alignment, kernel end, upper limit, then room.
    function pool_result_t free_page(logic [ADDR_W-1:0] page);
      pool_result_t res;
      res = '0;
      if ((page & PAGE_MASK) != '0) res.status = ST_MISALIGNED;
      else if (page < lowest_addr) res.status = ST_BELOW;
      else if (upper_lim < PAGE_BYTES || page > upper_lim - PAGE_BYTES) res.status = ST_ABOVE;
      else if (depth_used >= POOL_DEPTH) res.status = ST_FULL;
      else begin
        stash(page);
        res.status = ST_OK;
      end
      return res;
    endfunction

    function pool_result_t release_region(logic [ADDR_W-1:0] first, logic [ADDR_W-1:0] last);
      pool_result_t res;
      logic [ADDR_W-1:0] lo, floor_pg, hi, n, room;
      res = '0;
      // Rounding either bound up past the top of the address space takes nothing.
      if (first > ~PAGE_MASK || lowest_addr > ~PAGE_MASK) return res;
      lo = (first + PAGE_MASK) & ~PAGE_MASK;
      floor_pg = (lowest_addr + PAGE_MASK) & ~PAGE_MASK;
      if (floor_pg > lo) lo = floor_pg;
      hi = (last < upper_lim) ? last : upper_lim;
      if (hi < lo) return res;
      n = (hi - lo) >> PAGE_SHIFT;
      room = ADDR_W'(POOL_DEPTH - depth_used);
      if (n > room) begin
        n = room;
        res.status = ST_FULL;
      end
      for (int i = 0; i < int'(n); i++) stash(lo + (ADDR_W'(i) << PAGE_SHIFT));
      res.released = REL_W'(n);
      return res;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] page,
                               logic [ADDR_W-1:0] first, logic [ADDR_W-1:0] last);
      pool_result_t res;
      case (kind)
        REQ_ALLOC:  res = alloc_page();
        REQ_FREE:   res = free_page(page);
        REQ_REGION: res = release_region(first, last);
        default:    res = '0;
      endcase
      pending_results.push_back(res);
    endfunction

    task report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
      $display("%0t: %s mismatch, got %h, expected %h", $time, what, got, want);
      errors++;
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr,
                      logic [REL_W-1:0] released);
      pool_result_t want;
      if (pending_results.size() == 0) begin
        report("unrequested result status", ADDR_W'(status), '0);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report("status", ADDR_W'(status), ADDR_W'(want.status));
        if (addr !== want.alloc_addr) report("alloc_addr", addr, want.alloc_addr);
        if (released !== want.released)
          report("pages_released", ADDR_W'(released), ADDR_W'(want.released));
      end
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [REQ_W-1:0]     in_req_type;
  logic [ADDR_W-1:0]    in_page_addr;
  logic [ADDR_W-1:0]    in_region_start;
  logic [ADDR_W-1:0]    in_region_end;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [ADDR_W-1:0]    out_alloc_addr;
  logic [REL_W-1:0]     out_pages_released;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_wdata;

  page_pool_scoreboard sb;
  int unsigned send_idle_pct = 11;
  int quiet_cycles = 0;

  free_page_pool u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_page_addr       (in_page_addr),
    .in_region_start    (in_region_start),
    .in_region_end      (in_region_end),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_alloc_addr     (out_alloc_addr),
    .out_pages_released (out_pages_released),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_status, out_alloc_addr, out_pages_released);
  end

  // Any transaction on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly pages around the two bounds of the current window, some misaligned, some anywhere.
  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [ADDR_W-1:0] low_page, high_page, a;
    int unsigned r;
    low_page  = sb.lowest_addr & ~PAGE_MASK;
    high_page = sb.upper_lim & ~PAGE_MASK;
    r = $urandom_range(99);
    if (r < 40)
      a = low_page + (ADDR_W'($urandom_range(0, 34)) << PAGE_SHIFT) - (PAGE_BYTES << 1);
    else if (r < 70)
      a = high_page + PAGE_BYTES - (ADDR_W'($urandom_range(0, 34)) << PAGE_SHIFT);
    else if (r < 85)
      a = low_page + (ADDR_W'($urandom_range(0, 34)) << PAGE_SHIFT)
          + ADDR_W'($urandom_range(1, 32'(PAGE_MASK)));
    else
      a = rand64();
    return a;
  endfunction

  task automatic issue(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] page,
                       input logic [ADDR_W-1:0] first, input logic [ADDR_W-1:0] last);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_req_type     <= kind;
    in_page_addr    <= page;
    in_region_start <= first;
    in_region_end   <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(kind, page, first, last);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_window(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] up);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LOWEST;
    cfg_wdata <= lo;
    @(posedge clk);
    cfg_index <= CFG_UPPER;
    cfg_wdata <= up;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(CFG_LOWEST, lo);
    sb.set_reg(CFG_UPPER, up);
  endtask

  task automatic random_request();
    int unsigned pick, alloc_pct;
    logic [ADDR_W-1:0] a, b;
    // Lean toward allocation once the pool holds many pages.
    alloc_pct = (sb.depth_used > 300) ? 60 : 35;
    pick = $urandom_range(99);
    if (pick < 4) begin
      issue(REQ_UNUSED, rand64(), rand64(), rand64());
    end else if (pick < 4 + alloc_pct) begin
      issue(REQ_ALLOC, rand64(), rand64(), rand64());
    end else if (pick < 37 + alloc_pct) begin
      issue(REQ_FREE, pick_addr(), rand64(), rand64());
    end else begin
      a = pick_addr();
      pick = $urandom_range(99);
      if (pick < 78) begin
        b = a + (ADDR_W'($urandom_range(0, 12)) << PAGE_SHIFT);
        if ($urandom_range(1)) b = b + (ADDR_W'($urandom) & PAGE_MASK);
      end else if (pick < 88) begin
        b = a - (ADDR_W'($urandom_range(1, 4)) << PAGE_SHIFT);
      end else if (pick < 98) begin
        b = a + (ADDR_W'($urandom_range(13, 64)) << PAGE_SHIFT);
      end else begin
        b = rand64();
      end
      issue(REQ_REGION, rand64(), a, b);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] lo, up;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_req_type     = REQ_ALLOC;
    in_page_addr    = '0;
    in_region_start = '0;
    in_region_end   = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_LOWEST;
    cfg_wdata       = '0;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(REQ_ALLOC, '0, '0, '0);
    issue(REQ_FREE, 64'h1, '0, '0);
    // Misalignment is reported ahead of the limit check.
    issue(REQ_FREE, ALL_ONES, '0, '0);
    issue(REQ_FREE, LIMIT_RESET, '0, '0);
    issue(REQ_FREE, LIMIT_RESET - PAGE_BYTES, '0, '0);
    issue(REQ_FREE, '0, '0, '0);
    issue(REQ_FREE, '0, '0, '0);
    repeat (3) issue(REQ_ALLOC, '0, '0, '0);
    issue(REQ_ALLOC, ALL_ONES, ALL_ONES, ALL_ONES);
    issue(REQ_REGION, '0, 64'h1, 3 * PAGE_BYTES + 5);
    issue(REQ_REGION, '0, 5 * PAGE_BYTES, 2 * PAGE_BYTES);
    issue(REQ_REGION, '0, 7 * PAGE_BYTES, 7 * PAGE_BYTES);
    issue(REQ_REGION, '0, ALL_ONES, ALL_ONES);
    issue(REQ_REGION, '0, LIMIT_RESET - 3 * PAGE_BYTES, ALL_ONES);
    issue(REQ_UNUSED, rand64(), rand64(), rand64());
    issue(REQ_ALLOC, '0, '0, '0);
    settle();
    // An unaligned kernel end is rounded up for range release.
    program_window(64'h4000_0001, LIMIT_RESET);
    issue(REQ_FREE, 64'h4000_0000, '0, '0);
    issue(REQ_FREE, 64'h4020_0000, '0, '0);
    issue(REQ_REGION, '0, '0, 64'h4060_0000);

    for (int ph = 0; ph < 9; ph++) begin
      settle();
      lo = rand64();
      if ($urandom_range(1)) lo = lo & ~PAGE_MASK;
      up = lo + (ADDR_W'($urandom_range(0, 80)) << PAGE_SHIFT);
      if ($urandom_range(1)) up = up + ADDR_W'($urandom_range(0, 32'(PAGE_MASK)));
      case (ph)
        0: program_window('0, LIMIT_RESET);
        1: program_window('0, ALL_ONES);
        2: program_window(ALL_ONES - 3 * PAGE_BYTES + 1, ALL_ONES);
        3: program_window(ALL_ONES, '0);
        5: program_window('0, PAGE_BYTES - 1);
        default: program_window(lo, up);
      endcase
      send_idle_pct = (ph < 3) ? 11 : (ph < 6) ? 54 : 0;
      repeat (150) begin
        if ($urandom_range(49) == 0) settle();
        random_request();
      end
    end

    settle();
    program_window('0, LIMIT_RESET);
    issue(REQ_REGION, '0, '0, ALL_ONES);
    issue(REQ_FREE, 64'h4000_0000, '0, '0);
    issue(REQ_FREE, PAGE_BYTES + 1, '0, '0);
    issue(REQ_REGION, '0, '0, 4 * PAGE_BYTES);
    repeat (3) issue(REQ_ALLOC, '0, '0, '0);
    // Exactly as many pages as there is room for: no full status.
    issue(REQ_REGION, '0, 64'h4000_0000, 64'h4000_0000 + 3 * PAGE_BYTES);
    issue(REQ_REGION, '0, 64'h4000_0000, 64'h4000_0000 + PAGE_BYTES);
    issue(REQ_ALLOC, '0, '0, '0);

    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
